>>> hdl/gchv_pkg.sv
`default_nettype none

package gchv_pkg;

    // Header geometry
    localparam int HEADER_BYTES     = 512;
    localparam int MEDIA_UNIT_SHIFT = 9;
    localparam int COUNT_W          = $clog2(HEADER_BYTES + 1);

    // Field widths
    localparam int VDE_W  = 42;
    localparam int CART_W = 36;

    // Field offsets inside the header
    localparam logic [COUNT_W-1:0] OFS_MAGIC     = COUNT_W'(32'h100);
    localparam logic [COUNT_W-1:0] OFS_SIZE_CODE = COUNT_W'(32'h10D);
    localparam logic [COUNT_W-1:0] OFS_VERSION   = COUNT_W'(32'h10E);
    localparam logic [COUNT_W-1:0] OFS_FLAGS     = COUNT_W'(32'h10F);
    localparam logic [COUNT_W-1:0] OFS_END_PAGE  = COUNT_W'(32'h118);
    localparam logic [COUNT_W-1:0] OFS_ROOT_OFS  = COUNT_W'(32'h130);
    localparam logic [COUNT_W-1:0] OFS_ROOT_SIZE = COUNT_W'(32'h138);

    // Size codes
    localparam logic [7:0] SIZE_1G  = 8'hFA;
    localparam logic [7:0] SIZE_2G  = 8'hF8;
    localparam logic [7:0] SIZE_4G  = 8'hF0;
    localparam logic [7:0] SIZE_8G  = 8'hE0;
    localparam logic [7:0] SIZE_16G = 8'hE1;
    localparam logic [7:0] SIZE_32G = 8'hE2;

    // Configuration register reset values
    localparam logic [31:0] MAGIC_RESET    = 32'd1145128264;
    localparam logic [31:0] MIN_ROOT_RESET = 32'd16;
    localparam logic [31:0] MAX_ROOT_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        CFG_MAGIC    = 2'd0,
        CFG_MIN_ROOT = 2'd1,
        CFG_MAX_ROOT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNC     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_ROOT_SIZE = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [63:0]       part_offset;
        logic [63:0]       part_hdr_size;
        logic [7:0]        hdr_version;
        logic [7:0]        header_flags;
        logic [CART_W-1:0] cart_size_bytes;
        logic [VDE_W-1:0]  data_end;
    } out_t;

    // Captured header state, capture unit to check logic
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [31:0]        magic_word;
        logic [7:0]         size_code;
        logic [7:0]         version_byte;
        logic [7:0]         flags_byte;
        logic [31:0]        end_page;
        logic [63:0]        root_offset_word;
        logic [63:0]        root_size_word;
    } fields_t;

    // Card capacity in bytes for a size code, zero when unknown
    function automatic logic [CART_W-1:0] decode_capacity(input logic [7:0] code);
        logic [CART_W-1:0] cap;
        case (code)
            SIZE_1G:  cap = CART_W'(1) << 30;
            SIZE_2G:  cap = CART_W'(1) << 31;
            SIZE_4G:  cap = CART_W'(1) << 32;
            SIZE_8G:  cap = CART_W'(1) << 33;
            SIZE_16G: cap = CART_W'(1) << 34;
            SIZE_32G: cap = CART_W'(1) << 35;
            default:  cap = '0;
        endcase
        return cap;
    endfunction

endpackage

`default_nettype wire

>>> hdl/gchv_capture.sv
`default_nettype none

module gchv_capture import gchv_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic beat_en,
    input  wire in_t  beat,
    output fields_t   fields
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        magic_reg;
    logic [7:0]         size_code_reg;
    logic [7:0]         version_reg;
    logic [7:0]         flags_reg;
    logic [31:0]        end_page_reg;
    logic [63:0]        root_ofs_reg;
    logic [63:0]        root_size_reg;
    logic               in_header;

    assign in_header = (count_reg < COUNT_W'(HEADER_BYTES));

    // Advance the byte count, saturate at the header length, restart after the last beat
    always_comb begin
        count_next = count_reg;
        if (beat_en) begin
            if (beat.last_byte) begin
                count_next = '0;
            end else if (in_header) begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Capture header bytes; every field is rewritten before a full header is checked
    always_ff @(posedge aclk) begin
        if (beat_en && in_header) begin
            if (count_reg[COUNT_W-1:2] == OFS_MAGIC[COUNT_W-1:2]) begin
                magic_reg[{count_reg[1:0], 3'b000} +: 8] <= beat.data_byte;
            end
            if (count_reg == OFS_SIZE_CODE) begin
                size_code_reg <= beat.data_byte;
            end
            if (count_reg == OFS_VERSION) begin
                version_reg <= beat.data_byte;
            end
            if (count_reg == OFS_FLAGS) begin
                flags_reg <= beat.data_byte;
            end
            if (count_reg[COUNT_W-1:2] == OFS_END_PAGE[COUNT_W-1:2]) begin
                end_page_reg[{count_reg[1:0], 3'b000} +: 8] <= beat.data_byte;
            end
            if (count_reg[COUNT_W-1:3] == OFS_ROOT_OFS[COUNT_W-1:3]) begin
                root_ofs_reg[{count_reg[2:0], 3'b000} +: 8] <= beat.data_byte;
            end
            if (count_reg[COUNT_W-1:3] == OFS_ROOT_SIZE[COUNT_W-1:3]) begin
                root_size_reg[{count_reg[2:0], 3'b000} +: 8] <= beat.data_byte;
            end
        end
    end

    assign fields.byte_count       = count_reg;
    assign fields.magic_word       = magic_reg;
    assign fields.size_code        = size_code_reg;
    assign fields.version_byte     = version_reg;
    assign fields.flags_byte       = flags_reg;
    assign fields.end_page         = end_page_reg;
    assign fields.root_offset_word = root_ofs_reg;
    assign fields.root_size_word   = root_size_reg;

endmodule

`default_nettype wire

>>> hdl/gchv_check.sv
`default_nettype none

module gchv_check import gchv_pkg::*; (
    input  wire fields_t     fields,
    input  wire logic [31:0] expected_magic,
    input  wire logic [31:0] min_root_size,
    input  wire logic [31:0] max_root_size,
    output out_t             result
);

    logic        header_full;
    logic        magic_ok;
    logic [32:0] pages;
    logic [63:0] prod;
    logic        prod_ovf;
    logic        root_low;
    logic        size_bad;
    logic [64:0] root_sum;

    // The current beat completes the header when the count sits one short of it
    assign header_full = (fields.byte_count >= COUNT_W'(HEADER_BYTES - 1));
    assign magic_ok    = (fields.magic_word == expected_magic);

    // Valid-data end: (end page + 1) scaled by the media unit
    assign pages    = {1'b0, fields.end_page} + 33'd1;
    assign prod     = {31'b0, pages} << MEDIA_UNIT_SHIFT;
    assign prod_ovf = (prod[63:VDE_W] != '0);

    assign root_low = (fields.root_offset_word < 64'(HEADER_BYTES));
    assign size_bad = (fields.root_size_word < {32'b0, min_root_size}) ||
                      (fields.root_size_word > {32'b0, max_root_size});
    assign root_sum = {1'b0, fields.root_offset_word} + {1'b0, fields.root_size_word};

    // Run the checks in priority order; zero every field on a short stream or bad magic
    always_comb begin
        result = '0;
        if (!header_full) begin
            result.status = ST_TRUNC;
        end else if (!magic_ok) begin
            result.status = ST_BAD_MAGIC;
        end else begin
            if (prod_ovf) begin
                result.status = ST_OVERFLOW;
            end else if (root_low) begin
                result.status = ST_TRUNC;
            end else if (size_bad) begin
                result.status = ST_ROOT_SIZE;
            end else if (root_sum[64]) begin
                result.status = ST_OVERFLOW;
            end else begin
                result.status = ST_OK;
            end
            result.part_offset     = fields.root_offset_word;
            result.part_hdr_size   = fields.root_size_word;
            result.hdr_version     = fields.version_byte;
            result.header_flags    = fields.flags_byte;
            result.cart_size_bytes = decode_capacity(fields.size_code);
            result.data_end        = prod[VDE_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hdl/gamecard_header_validator_top.sv
`default_nettype none

// Channel   Ports                       Beat
// input     s_valid s_ready s_data      one image byte, last_byte closes the image
// result    m_valid m_ready m_data      status and parsed header fields
// config    cfg_valid cfg_ready         cfg_index selects, cfg_data is the value
//
// One byte beat per cycle while s_ready is high. The last beat's result is registered
// in the output register, or the skid while it waits; fields feed the checks directly.
// A two-entry output stage (result register plus skid) keeps s_ready registered;
// input stalls only while both entries hold results.
// Reset is synchronous, active low; it restores the configuration defaults.
module gamecard_header_validator_top import gchv_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] magic_cfg_reg;
    logic [31:0] min_root_reg;
    logic [31:0] max_root_reg;
    logic        in_fire;
    logic        result_fire;
    fields_t     fields;
    out_t        result;
    logic        out_valid_reg;
    out_t        out_data_reg;
    logic        skid_valid_reg;
    out_t        skid_data_reg;

    assign cfg_ready   = 1'b1;
    assign s_ready     = !skid_valid_reg;
    assign in_fire     = s_valid && s_ready;
    assign result_fire = in_fire && s_data.last_byte;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_cfg_reg <= MAGIC_RESET;
            min_root_reg  <= MIN_ROOT_RESET;
            max_root_reg  <= MAX_ROOT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAGIC:    magic_cfg_reg <= cfg_data;
                CFG_MIN_ROOT: min_root_reg  <= cfg_data;
                CFG_MAX_ROOT: max_root_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    gchv_capture u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat_en (in_fire),
        .beat    (s_data),
        .fields  (fields)
    );

    gchv_check u_check (
        .fields         (fields),
        .expected_magic (magic_cfg_reg),
        .min_root_size  (min_root_reg),
        .max_root_size  (max_root_reg),
        .result         (result)
    );

    // Advance the output register; park a new result in the skid while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= result_fire;
            end
        end else if (result_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (result_fire) begin
                out_data_reg <= result;
            end
        end else if (result_fire) begin
            skid_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The skid only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // After a last beat, the output register always holds a result next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        result_fire |=> out_valid_reg)
        else $error("last beat accepted without a result");

    // The stream restarts after the last beat
    a_count_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        result_fire |=> (fields.byte_count == '0))
        else $error("byte count not cleared after the last beat");

    // The byte count never runs past the header
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        fields.byte_count <= COUNT_W'(HEADER_BYTES))
        else $error("byte count beyond header length");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

import gchv_pkg::*;

// Scoreboard of the header parser: mirrors the config and the capture state
class header_scoreboard;
    logic [31:0]        magic_cfg;
    logic [31:0]        min_cfg;
    logic [31:0]        max_cfg;
    logic [COUNT_W-1:0] count;
    logic [31:0]        magic_word;
    logic [7:0]         size_code;
    logic [7:0]         version_byte;
    logic [7:0]         flags_byte;
    logic [31:0]        end_page;
    logic [63:0]        root_ofs;
    logic [63:0]        root_size;
    out_t               pending_results[$];
    int                 errors;

    function new();
        magic_cfg = MAGIC_RESET;
        min_cfg   = MIN_ROOT_RESET;
        max_cfg   = MAX_ROOT_RESET;
        errors    = 0;
        clear_image();
    endfunction

    function void clear_image();
        count        = '0;
        magic_word   = '0;
        size_code    = '0;
        version_byte = '0;
        flags_byte   = '0;
        end_page     = '0;
        root_ofs     = '0;
        root_size    = '0;
    endfunction

    function void write_register(cfg_idx_t idx, logic [31:0] value);
        case (idx)
            CFG_MAGIC:    magic_cfg = value;
            CFG_MIN_ROOT: min_cfg = value;
            CFG_MAX_ROOT: max_cfg = value;
            default:      ;
        endcase
    endfunction

    // Capacity in bytes for a size code, zero when unknown
    function logic [CART_W-1:0] capacity(logic [7:0] code);
        logic [CART_W-1:0] gib;
        gib = CART_W'(1) << 30;
        case (code)
            SIZE_1G:  return gib;
            SIZE_2G:  return gib << 1;
            SIZE_4G:  return gib << 2;
            SIZE_8G:  return gib << 3;
            SIZE_16G: return gib << 4;
            SIZE_32G: return gib << 5;
            default:  return '0;
        endcase
    endfunction

    // Capture one byte; on the closing beat, queue the expected result
    function void note_byte(in_t beat);
        int               pos;
        logic [63:0]      product;
        logic [64:0]      root_sum;
        out_t             want;
        pos = int'(count);
        if (count < HEADER_BYTES) begin
            if (pos >= int'(OFS_MAGIC) && pos < int'(OFS_MAGIC) + 4)
                magic_word[8*(pos - int'(OFS_MAGIC)) +: 8] = beat.data_byte;
            else if (pos == int'(OFS_SIZE_CODE))
                size_code = beat.data_byte;
            else if (pos == int'(OFS_VERSION))
                version_byte = beat.data_byte;
            else if (pos == int'(OFS_FLAGS))
                flags_byte = beat.data_byte;
            else if (pos >= int'(OFS_END_PAGE) && pos < int'(OFS_END_PAGE) + 4)
                end_page[8*(pos - int'(OFS_END_PAGE)) +: 8] = beat.data_byte;
            else if (pos >= int'(OFS_ROOT_OFS) && pos < int'(OFS_ROOT_OFS) + 8)
                root_ofs[8*(pos - int'(OFS_ROOT_OFS)) +: 8] = beat.data_byte;
            else if (pos >= int'(OFS_ROOT_SIZE) && pos < int'(OFS_ROOT_SIZE) + 8)
                root_size[8*(pos - int'(OFS_ROOT_SIZE)) +: 8] = beat.data_byte;
            count = count + 1'b1;
        end
        if (!beat.last_byte)
            return;

        want = '0;
        if (count < HEADER_BYTES) begin
            want.status = ST_TRUNC;
        end else if (magic_word != magic_cfg) begin
            want.status = ST_BAD_MAGIC;
        end else begin
            product  = (64'(end_page) + 64'd1) << MEDIA_UNIT_SHIFT;
            root_sum = 65'(root_ofs) + 65'(root_size);
            if ((product >> VDE_W) != 0)
                want.status = ST_OVERFLOW;
            else if (root_ofs < HEADER_BYTES)
                want.status = ST_TRUNC;
            else if (root_size < 64'(min_cfg) || root_size > 64'(max_cfg))
                want.status = ST_ROOT_SIZE;
            else if (root_sum[64])
                want.status = ST_OVERFLOW;
            else
                want.status = ST_OK;
            want.part_offset     = root_ofs;
            want.part_hdr_size   = root_size;
            want.hdr_version     = version_byte;
            want.header_flags    = flags_byte;
            want.cart_size_bytes = capacity(size_code);
            want.data_end        = product[VDE_W-1:0];
        end
        pending_results.push_back(want);
        clear_image();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(out_t got);
        out_t want;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("part_offset", want.part_offset, got.part_offset);
        compare_field("part_hdr_size", want.part_hdr_size, got.part_hdr_size);
        compare_field("hdr_version", 64'(want.hdr_version), 64'(got.hdr_version));
        compare_field("header_flags", 64'(want.header_flags), 64'(got.header_flags));
        compare_field("cart_size_bytes", 64'(want.cart_size_bytes),
                      64'(got.cart_size_bytes));
        compare_field("data_end", 64'(want.data_end), 64'(got.data_end));
    endfunction
endclass

module testbench;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int IMG_BYTES    = HEADER_BYTES + 64;
    localparam int PHASE_BYTES  = 24;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    header_scoreboard board;
    logic [7:0]       img [IMG_BYTES];
    logic [31:0]      cur_magic;
    logic [31:0]      cur_min;
    logic [31:0]      cur_max;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               holds_asked;
    int               holds_done;
    int               quiet_cycles;

    gamecard_header_validator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        m_ready    = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    // Abort when no channel moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic configure(logic [31:0] magic, logic [31:0] min_size,
                             logic [31:0] max_size);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_MIN_ROOT, min_size);
        write_reg(CFG_MAX_ROOT, max_size);
        cfg_valid <= 1'b0;
        cur_magic = magic;
        cur_min   = min_size;
        cur_max   = max_size;
    endtask

    // Offer one byte beat, with an optional gap first; return at the next falling edge
    task automatic send_beat(in_t beat);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_byte(beat);
        @(negedge aclk);
    endtask

    function automatic void put_field(int ofs, logic [63:0] value, int nbytes);
        for (int i = 0; i < nbytes; i++)
            img[ofs + i] = value[8*i +: 8];
    endfunction

    // Fill the image with random bytes and place the header fields
    function automatic void build_header(logic [31:0] magic, logic [7:0] code,
                                         logic [7:0] ver, logic [7:0] flg,
                                         logic [31:0] endpg, logic [63:0] rofs,
                                         logic [63:0] rsize);
        for (int i = 0; i < IMG_BYTES; i++)
            img[i] = 8'($urandom);
        put_field(int'(OFS_MAGIC), 64'(magic), 4);
        put_field(int'(OFS_SIZE_CODE), 64'(code), 1);
        put_field(int'(OFS_VERSION), 64'(ver), 1);
        put_field(int'(OFS_FLAGS), 64'(flg), 1);
        put_field(int'(OFS_END_PAGE), 64'(endpg), 4);
        put_field(int'(OFS_ROOT_OFS), rofs, 8);
        put_field(int'(OFS_ROOT_SIZE), rsize, 8);
    endfunction

    task automatic send_image(int len);
        in_t beat;
        for (int i = 0; i < len; i++) begin
            beat.data_byte = img[i];
            beat.last_byte = (i == len - 1);
            send_beat(beat);
        end
    endtask

    // Drop valid, wait for every pending result, then let the pipe settle
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic directed_images();
        // Short stream of one byte
        build_header(cur_magic, SIZE_1G, 8'h00, 8'h00, 32'h0, 64'd512, 64'(cur_min));
        send_image(1);
        // Clean header with every field set, trailing bytes ignored
        build_header(cur_magic, SIZE_32G, 8'h5A, 8'hA5, 32'h0123_4567, 64'd4096,
                     64'(cur_max));
        send_image(HEADER_BYTES + 4);
        settle();
        // New configuration, then a root end that wraps by one with full end page
        configure($urandom, 32'd16, 32'd64);
        build_header(cur_magic, SIZE_8G, 8'h01, 8'h80, 32'hFFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF - 64'd15, 64'd16);
        send_image(HEADER_BYTES);
    endtask

    // Short image of random bytes
    task automatic send_random_image(int len);
        for (int i = 0; i < len; i++)
            img[i] = 8'($urandom);
        send_image(len);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        int bytes_sent;
        int images_sent;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        bytes_sent     = 0;
        images_sent    = 0;
        while (bytes_sent < PHASE_BYTES || images_sent < 4) begin
            len = $urandom_range(1, 6);
            send_random_image(len);
            images_sent++;
            bytes_sent = bytes_sent + len;
        end
        settle();
    endtask

    // Hold off the result side while short images pile up behind it
    task automatic pressure_burst();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked++;
        for (int i = 0; i < 6; i++) begin
            build_header(cur_magic, SIZE_8G, 8'($urandom), 8'($urandom), $urandom,
                         64'd512, 64'(cur_min));
            send_image($urandom_range(1, 4));
        end
        settle();
    endtask

    initial begin
        board          = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cur_magic      = MAGIC_RESET;
        cur_min        = MIN_ROOT_RESET;
        cur_max        = MAX_ROOT_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked    = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_images();
        settle();

        configure($urandom, 32'h0, 32'hFFFF_FFFF);
        run_phase(86, 0);
        configure(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(0, 86);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        run_phase(19, 19);
        configure(MAGIC_RESET, MIN_ROOT_RESET, MAX_ROOT_RESET);
        pressure_burst();
        run_phase(0, 0);
        configure($urandom, 32'($urandom_range(0, 4096)), 32'($urandom_range(4096, 1 << 24)));
        run_phase(19, 19);

        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> gamecard_header_validator_top.f
hdl/gchv_pkg.sv
hdl/gchv_capture.sv
hdl/gchv_check.sv
hdl/gamecard_header_validator_top.sv
tb/testbench.sv
